FILE: src/rei_pkg.sv
// ----------------------------------------------------------------------------
// rei_pkg
// Shared types and index constants for the rectangle edge / segment
// intersection pipeline.
// ----------------------------------------------------------------------------
package rei_pkg;

	// Rectangle corners, in the order the edges visit them
	localparam int unsigned CORNER_TL = 0;
	localparam int unsigned CORNER_TR = 1;
	localparam int unsigned CORNER_BR = 2;
	localparam int unsigned CORNER_BL = 3;
	localparam int unsigned NUM_CORNERS = 4;

	// Rectangle edges
	localparam int unsigned EDGE_TOP = 0;
	localparam int unsigned EDGE_RIGHT = 1;
	localparam int unsigned EDGE_BOTTOM = 2;
	localparam int unsigned EDGE_LEFT = 3;
	localparam int unsigned NUM_EDGES = 4;

	// Sign of a cross product: both clear means zero
	typedef struct packed {
		logic pos;
		logic neg;
	} sign_t;

	// Load enables of the multiply and sign stages
	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
	} stage_ctl_t;

endpackage

FILE: src/rei_seg_if.sv
// ----------------------------------------------------------------------------
// rei_seg_if
// Query channel: one rectangle and one line segment per transfer.
// ----------------------------------------------------------------------------
interface rei_seg_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] rect_right;
	logic signed [COORD_BITS-1:0] rect_left;
	logic signed [COORD_BITS-1:0] rect_top;
	logic signed [COORD_BITS-1:0] rect_bottom;
	logic signed [COORD_BITS-1:0] seg_start_x;
	logic signed [COORD_BITS-1:0] seg_start_y;
	logic signed [COORD_BITS-1:0] seg_end_x;
	logic signed [COORD_BITS-1:0] seg_end_y;

	modport source (
		output valid, rect_right, rect_left, rect_top, rect_bottom,
		       seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		input  ready
	);

	modport sink (
		input  valid, rect_right, rect_left, rect_top, rect_bottom,
		       seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		output ready
	);
endinterface

FILE: src/rei_hit_if.sv
// ----------------------------------------------------------------------------
// rei_hit_if
// Result channel: one hit flag per transfer.
// ----------------------------------------------------------------------------
interface rei_hit_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (
		output valid, hit,
		input  ready
	);

	modport sink (
		input  valid, hit,
		output ready
	);
endinterface

FILE: src/rei_front.sv
// ----------------------------------------------------------------------------
// rei_front
// First stage: segment direction, corner offsets from the segment start and
// the per-edge test of the segment endpoints against each edge line.
// ----------------------------------------------------------------------------
module rei_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         load,
	input  logic signed [COORD_BITS-1:0] rect_right,
	input  logic signed [COORD_BITS-1:0] rect_left,
	input  logic signed [COORD_BITS-1:0] rect_top,
	input  logic signed [COORD_BITS-1:0] rect_bottom,
	input  logic signed [COORD_BITS-1:0] seg_start_x,
	input  logic signed [COORD_BITS-1:0] seg_start_y,
	input  logic signed [COORD_BITS-1:0] seg_end_x,
	input  logic signed [COORD_BITS-1:0] seg_end_y,
	output logic signed [COORD_BITS:0]   dx_s1,
	output logic signed [COORD_BITS:0]   dy_s1,
	output logic signed [COORD_BITS:0]   qx_l_s1,
	output logic signed [COORD_BITS:0]   qx_r_s1,
	output logic signed [COORD_BITS:0]   qy_t_s1,
	output logic signed [COORD_BITS:0]   qy_b_s1,
	output logic [rei_pkg::NUM_EDGES-1:0] edge_miss_s1
);
	localparam int DW = COORD_BITS + 1;

	logic [rei_pkg::NUM_EDGES-1:0] edge_miss;

	// Both endpoints strictly on one side of a non-degenerate edge line
	always_comb begin
		edge_miss = '0;
		edge_miss[rei_pkg::EDGE_TOP] = (rect_right != rect_left) &&
			((seg_start_y > rect_top && seg_end_y > rect_top) ||
			 (seg_start_y < rect_top && seg_end_y < rect_top));
		edge_miss[rei_pkg::EDGE_RIGHT] = (rect_bottom != rect_top) &&
			((seg_start_x > rect_right && seg_end_x > rect_right) ||
			 (seg_start_x < rect_right && seg_end_x < rect_right));
		edge_miss[rei_pkg::EDGE_BOTTOM] = (rect_left != rect_right) &&
			((seg_start_y > rect_bottom && seg_end_y > rect_bottom) ||
			 (seg_start_y < rect_bottom && seg_end_y < rect_bottom));
		edge_miss[rei_pkg::EDGE_LEFT] = (rect_top != rect_bottom) &&
			((seg_start_x > rect_left && seg_end_x > rect_left) ||
			 (seg_start_x < rect_left && seg_end_x < rect_left));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dx_s1        <= DW'(seg_end_x) - DW'(seg_start_x);
			dy_s1        <= DW'(seg_end_y) - DW'(seg_start_y);
			qx_l_s1      <= DW'(rect_left) - DW'(seg_start_x);
			qx_r_s1      <= DW'(rect_right) - DW'(seg_start_x);
			qy_t_s1      <= DW'(rect_top) - DW'(seg_start_y);
			qy_b_s1      <= DW'(rect_bottom) - DW'(seg_start_y);
			edge_miss_s1 <= edge_miss;
		end
	end
endmodule

FILE: src/rei_cross.sv
// ----------------------------------------------------------------------------
// rei_cross
// Side of one rectangle corner against the segment line: two products in
// one stage, difference and sign in the next.
// ----------------------------------------------------------------------------
module rei_cross #(
	parameter int COORD_BITS = 12
) (
	input  logic                       clk,
	input  rei_pkg::stage_ctl_t        ctl,
	input  logic signed [COORD_BITS:0] dx,
	input  logic signed [COORD_BITS:0] dy,
	input  logic signed [COORD_BITS:0] qx,
	input  logic signed [COORD_BITS:0] qy,
	output rei_pkg::sign_t             side_s3
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;

	logic signed [PW-1:0] prod_a_s2;
	logic signed [PW-1:0] prod_b_s2;
	logic signed [XW-1:0] cross_val;

	assign cross_val = XW'(prod_a_s2) - XW'(prod_b_s2);

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			prod_a_s2 <= PW'(dx) * PW'(qy);
			prod_b_s2 <= PW'(dy) * PW'(qx);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			side_s3.pos <= !cross_val[XW-1] && (|cross_val);
			side_s3.neg <= cross_val[XW-1];
		end
	end
endmodule

FILE: src/rect_edge_segment_intersect_unit.sv
// ----------------------------------------------------------------------------
// rect_edge_segment_intersect_unit
// Reports whether a line segment crosses or touches any edge of an
// axis-aligned rectangle.
// ----------------------------------------------------------------------------
// Channels: query (sink) carries the rectangle bounds and the two segment
// endpoints; result (source) carries one hit flag per query. A transfer
// happens on a rising clk edge with valid and ready both high.
// Each edge uses the two-sided straddle test; a zero cross product counts as
// touching. The edge-line side checks are plain compares, the segment-line
// side of each of the four corners is one cross product.
// Pipeline: four register stages (differences, products, cross-product
// signs, edge combine into the output register).
// Throughput: one query per cycle unless stalled; each stage holds one item.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty and
// ready.
// Stall: a result not taken holds in the output register; each stage keeps
// advancing into an empty slot ahead of it, so up to four queries are held
// before query.ready drops.
// ----------------------------------------------------------------------------
module rect_edge_segment_intersect_unit #(
	parameter int COORD_BITS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	rei_seg_if.sink        query,
	rei_hit_if.source      result
);
	logic signed [COORD_BITS:0] dx_s1;
	logic signed [COORD_BITS:0] dy_s1;
	logic signed [COORD_BITS:0] qx_l_s1;
	logic signed [COORD_BITS:0] qx_r_s1;
	logic signed [COORD_BITS:0] qy_t_s1;
	logic signed [COORD_BITS:0] qy_b_s1;

	logic [rei_pkg::NUM_EDGES-1:0] edge_miss_s1;
	logic [rei_pkg::NUM_EDGES-1:0] edge_miss_s2;
	logic [rei_pkg::NUM_EDGES-1:0] edge_miss_s3;

	rei_pkg::sign_t side_s3 [rei_pkg::NUM_CORNERS];

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic hit_s4;
	logic adv1, adv2, adv3, adv4;
	rei_pkg::stage_ctl_t ctl;
	logic [rei_pkg::NUM_EDGES-1:0] seg_miss;
	logic hit;

	// Advance a stage when it is empty or its successor advances
	assign adv4 = !valid_s4 || result.ready;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign ctl.adv_s2 = adv2;
	assign ctl.adv_s3 = adv3;

	assign query.ready  = adv1;
	assign result.valid = valid_s4;
	assign result.hit   = hit_s4;

	rei_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.load         (adv1),
		.rect_right   (query.rect_right),
		.rect_left    (query.rect_left),
		.rect_top     (query.rect_top),
		.rect_bottom  (query.rect_bottom),
		.seg_start_x  (query.seg_start_x),
		.seg_start_y  (query.seg_start_y),
		.seg_end_x    (query.seg_end_x),
		.seg_end_y    (query.seg_end_y),
		.dx_s1        (dx_s1),
		.dy_s1        (dy_s1),
		.qx_l_s1      (qx_l_s1),
		.qx_r_s1      (qx_r_s1),
		.qy_t_s1      (qy_t_s1),
		.qy_b_s1      (qy_b_s1),
		.edge_miss_s1 (edge_miss_s1)
	);

	rei_cross #(.COORD_BITS(COORD_BITS)) u_cross_tl (
		.clk(clk), .ctl(ctl), .dx(dx_s1), .dy(dy_s1), .qx(qx_l_s1), .qy(qy_t_s1),
		.side_s3(side_s3[rei_pkg::CORNER_TL])
	);

	rei_cross #(.COORD_BITS(COORD_BITS)) u_cross_tr (
		.clk(clk), .ctl(ctl), .dx(dx_s1), .dy(dy_s1), .qx(qx_r_s1), .qy(qy_t_s1),
		.side_s3(side_s3[rei_pkg::CORNER_TR])
	);

	rei_cross #(.COORD_BITS(COORD_BITS)) u_cross_br (
		.clk(clk), .ctl(ctl), .dx(dx_s1), .dy(dy_s1), .qx(qx_r_s1), .qy(qy_b_s1),
		.side_s3(side_s3[rei_pkg::CORNER_BR])
	);

	rei_cross #(.COORD_BITS(COORD_BITS)) u_cross_bl (
		.clk(clk), .ctl(ctl), .dx(dx_s1), .dy(dy_s1), .qx(qx_l_s1), .qy(qy_b_s1),
		.side_s3(side_s3[rei_pkg::CORNER_BL])
	);

	// Drop an edge when both of its corners sit strictly on one side
	always_comb begin
		seg_miss = '0;
		seg_miss[rei_pkg::EDGE_TOP] =
			(side_s3[rei_pkg::CORNER_TL].pos && side_s3[rei_pkg::CORNER_TR].pos) ||
			(side_s3[rei_pkg::CORNER_TL].neg && side_s3[rei_pkg::CORNER_TR].neg);
		seg_miss[rei_pkg::EDGE_RIGHT] =
			(side_s3[rei_pkg::CORNER_TR].pos && side_s3[rei_pkg::CORNER_BR].pos) ||
			(side_s3[rei_pkg::CORNER_TR].neg && side_s3[rei_pkg::CORNER_BR].neg);
		seg_miss[rei_pkg::EDGE_BOTTOM] =
			(side_s3[rei_pkg::CORNER_BR].pos && side_s3[rei_pkg::CORNER_BL].pos) ||
			(side_s3[rei_pkg::CORNER_BR].neg && side_s3[rei_pkg::CORNER_BL].neg);
		seg_miss[rei_pkg::EDGE_LEFT] =
			(side_s3[rei_pkg::CORNER_BL].pos && side_s3[rei_pkg::CORNER_TL].pos) ||
			(side_s3[rei_pkg::CORNER_BL].neg && side_s3[rei_pkg::CORNER_TL].neg);
		hit = |(~(seg_miss | edge_miss_s3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= query.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			if (adv4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			edge_miss_s2 <= edge_miss_s1;
		end
		if (adv3) begin
			edge_miss_s3 <= edge_miss_s2;
		end
		if (adv4) begin
			hit_s4 <= hit;
		end
	end

`ifndef SYNTHESIS
	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && !result.ready) |-> !query.ready)
		else $error("query accepted while every stage is full and stalled");

	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(query.valid && query.ready) |=> valid_s1)
		else $error("transferred query did not reach the first stage");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !valid_s3) |=> !result.valid)
		else $error("result repeated after transfer");

	a_all_one_side_misses: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && adv3 &&
		 side_s3[rei_pkg::CORNER_TL].pos && side_s3[rei_pkg::CORNER_TR].pos &&
		 side_s3[rei_pkg::CORNER_BR].pos && side_s3[rei_pkg::CORNER_BL].pos)
		|=> !hit_s4)
		else $error("hit reported with all corners on one side of the segment");
`endif
endmodule
